// ----- rtl/ppipsg_pkg.sv -----
// shared types, codes and constants for the parallel port with sound-chip bus control
package ppipsg_pkg;

    // register and field widths
    localparam int unsigned MachineIdWidth = 3;
    localparam logic [MachineIdWidth-1:0] MachineIdReset = 3'd7;

    // operation codes
    localparam logic [1:0] OP_REG_WRITE  = 2'd0;
    localparam logic [1:0] OP_REG_READ   = 2'd1;
    localparam logic [1:0] OP_TAPE_READ  = 2'd2;
    localparam logic [1:0] OP_TAPE_WRITE = 2'd3;

    // port select codes
    localparam logic [1:0] PORT_A       = 2'd0;
    localparam logic [1:0] PORT_B       = 2'd1;
    localparam logic [1:0] PORT_C       = 2'd2;
    localparam logic [1:0] PORT_CONTROL = 2'd3;

    // sound-chip bus modes, port C bits 7:6
    localparam logic [1:0] BUS_INACTIVE = 2'd0;
    localparam logic [1:0] BUS_READ     = 2'd1;
    localparam logic [1:0] BUS_WRITE    = 2'd2;
    localparam logic [1:0] BUS_LATCH    = 2'd3;

    // byte constants
    localparam logic [7:0] TapeThreshold = 8'h85;
    localparam logic [7:0] RefreshBit    = 8'h10;
    localparam logic [7:0] TapeLow       = 8'h40;
    localparam logic [7:0] TapeHigh      = 8'hC0;
    localparam logic [7:0] ModeMaskBits  = 8'h09;
    localparam logic [7:0] MaskLowNibble = 8'h0F;
    localparam logic [7:0] MaskHighNibble = 8'hF0;
    localparam logic [7:0] ByteAllOnes   = 8'hFF;

    // port C bit positions
    localparam int unsigned MotorBitPos   = 4;
    localparam int unsigned TapeOutBitPos = 5;

    // one input item
    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] port_select;
        logic [7:0] write_data;
        logic [7:0] psg_read_data;
        logic       vsync;
        logic [7:0] tape_sample;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       psg_write_valid;
        logic [7:0] psg_write_data;
        logic [3:0] psg_reg_index;
        logic [3:0] keyboard_row;
        logic       motor_on;
        logic       tape_out_valid;
        logic [7:0] tape_out_sample;
    } res_item_t;

endpackage

// ----- rtl/ppi_parallel_port_with_psg_control_top.sv -----
// top level: input register, execute logic, result register and config register
//
// Parallel port that drives a sound-chip bus, keyboard row select and tape.
// Input channel s_*: one item per bus access or tape tick (opcode, port
// select, write byte, sound-chip read byte, vsync, tape sample).
// Result channel m_*: exactly one result item for every input item, in order.
// Config channel cfg_*: writes the 3-bit machine id shown in port B bits 3:1;
// cfg_ready is always high, and writes are expected only while idle.
// An accepted item is held in the input register; its result is computed
// combinationally and registered in the result register, which drives
// m_valid and the result ports.
// Throughput: one item per cycle while results are taken; all the port logic
// is one short combinational pass between the input and result registers.
// Stall: when m_ready is low the result register holds, the input register
// fills, and s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): both registers empty, all port latches,
// read mask, bus mode, register index and tape bit cleared, machine id 7.
module ppi_parallel_port_with_psg_control_top
    import ppipsg_pkg::*;
#(
    parameter int unsigned MACHINE_ID_W = MachineIdWidth
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration write
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [MACHINE_ID_W-1:0] cfg_data,
    // input items
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_opcode,
    input  logic [1:0]              s_port_select,
    input  logic [7:0]              s_write_data,
    input  logic [7:0]              s_psg_read_data,
    input  logic                    s_vsync,
    input  logic [7:0]              s_tape_sample,
    // result items
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_read_data,
    output logic                    m_psg_write_valid,
    output logic [7:0]              m_psg_write_data,
    output logic [3:0]              m_psg_reg_index,
    output logic [3:0]              m_keyboard_row,
    output logic                    m_motor_on,
    output logic                    m_tape_out_valid,
    output logic [7:0]              m_tape_out_sample
);

    logic [MACHINE_ID_W-1:0] machine_id_reg;
    logic                    in_valid_reg;
    in_item_t                in_item_reg;
    logic                    out_valid_reg;
    res_item_t               out_item_reg;
    res_item_t               exec_result;
    logic                    advance;

    // handshake control
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            machine_id_reg <= MACHINE_ID_W'(MachineIdReset);
        end else if (cfg_valid) begin
            machine_id_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.opcode        <= s_opcode;
            in_item_reg.port_select   <= s_port_select;
            in_item_reg.write_data    <= s_write_data;
            in_item_reg.psg_read_data <= s_psg_read_data;
            in_item_reg.vsync         <= s_vsync;
            in_item_reg.tape_sample   <= s_tape_sample;
        end
    end

    // port state and item logic
    ppipsg_exec #(
        .MACHINE_ID_W(MACHINE_ID_W)
    ) u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (advance),
        .item      (in_item_reg),
        .machine_id(machine_id_reg),
        .result    (exec_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= exec_result;
        end
    end

    // result ports
    assign m_valid           = out_valid_reg;
    assign m_read_data       = out_item_reg.read_data;
    assign m_psg_write_valid = out_item_reg.psg_write_valid;
    assign m_psg_write_data  = out_item_reg.psg_write_data;
    assign m_psg_reg_index   = out_item_reg.psg_reg_index;
    assign m_keyboard_row    = out_item_reg.keyboard_row;
    assign m_motor_on        = out_item_reg.motor_on;
    assign m_tape_out_valid  = out_item_reg.tape_out_valid;
    assign m_tape_out_sample = out_item_reg.tape_out_sample;

endmodule

// ----- rtl/ppipsg_exec.sv -----
// port state registers and the per-item update and result logic
module ppipsg_exec
    import ppipsg_pkg::*;
#(
    parameter int unsigned MACHINE_ID_W = MachineIdWidth
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    item_fire,
    input  in_item_t                item,
    input  logic [MACHINE_ID_W-1:0] machine_id,
    output res_item_t               result
);

    logic [7:0] port_a_reg, port_a_next;
    logic [7:0] port_c_reg, port_c_next;
    logic [7:0] c_mask_reg, c_mask_next;
    logic [1:0] bus_mode_reg, bus_mode_next;
    logic [3:0] psg_index_reg, psg_index_next;
    logic       tape_in_reg, tape_in_next;

    logic       bus_apply;
    logic       psg_wr;
    logic [7:0] read_byte;
    logic [7:0] port_b_byte;
    logic [7:0] bit_sel;
    logic       tape_valid;
    logic [7:0] tape_val;

    // port B status byte
    always_comb begin
        port_b_byte = RefreshBit;
        port_b_byte[0] = item.vsync;
        port_b_byte[7] = tape_in_reg;
        port_b_byte[MACHINE_ID_W:1] = machine_id;
    end

    assign bit_sel = 8'h01 << item.write_data[3:1];

    // next state and result fields
    always_comb begin
        port_a_next    = port_a_reg;
        port_c_next    = port_c_reg;
        c_mask_next    = c_mask_reg;
        bus_mode_next  = bus_mode_reg;
        tape_in_next   = tape_in_reg;
        bus_apply      = 1'b0;
        read_byte      = ByteAllOnes;
        tape_valid     = 1'b0;
        tape_val       = 8'h00;

        unique case (item.opcode)
            OP_REG_WRITE: begin
                unique case (item.port_select)
                    PORT_A: begin
                        port_a_next = item.write_data;
                        bus_apply   = 1'b1;
                    end
                    PORT_C: begin
                        port_c_next   = item.write_data;
                        bus_mode_next = item.write_data[7:6];
                        bus_apply     = 1'b1;
                    end
                    PORT_CONTROL: begin
                        if (item.write_data[7]) begin
                            port_a_next = 8'h00;
                            if ((item.write_data & ModeMaskBits) == ModeMaskBits) begin
                                c_mask_next = 8'h00;
                            end else if (item.write_data[3]) begin
                                c_mask_next = MaskLowNibble;
                            end else if (item.write_data[0]) begin
                                c_mask_next = MaskHighNibble;
                            end else begin
                                c_mask_next = ByteAllOnes;
                            end
                        end else if (item.write_data[0]) begin
                            port_c_next = port_c_reg | bit_sel;
                        end else begin
                            port_c_next = port_c_reg & ~bit_sel;
                        end
                    end
                    default: begin
                        // port B write has no effect
                    end
                endcase
            end
            OP_REG_READ: begin
                unique case (item.port_select)
                    PORT_A: begin
                        if (bus_mode_reg == BUS_READ) begin
                            read_byte = item.psg_read_data;
                        end
                    end
                    PORT_B:  read_byte = port_b_byte;
                    PORT_C:  read_byte = port_c_reg & c_mask_reg;
                    default: read_byte = ByteAllOnes;
                endcase
            end
            OP_TAPE_READ: begin
                tape_in_next = port_c_reg[MotorBitPos] && (item.tape_sample > TapeThreshold);
            end
            default: begin
                if (port_c_reg[MotorBitPos]) begin
                    tape_valid = 1'b1;
                    tape_val   = port_c_reg[TapeOutBitPos] ? TapeHigh : TapeLow;
                end
            end
        endcase

        // sound-chip bus action after a port A or port C write
        psg_index_next = psg_index_reg;
        if (bus_apply && bus_mode_next == BUS_LATCH) begin
            psg_index_next = port_a_next[3:0];
        end
        psg_wr = bus_apply && (bus_mode_next == BUS_WRITE);
    end

    // result item, taken from the updated state
    always_comb begin
        result.read_data       = read_byte;
        result.psg_write_valid = psg_wr;
        result.psg_write_data  = psg_wr ? port_a_next : 8'h00;
        result.psg_reg_index   = psg_index_next;
        result.keyboard_row    = port_c_next[3:0];
        result.motor_on        = port_c_next[MotorBitPos];
        result.tape_out_valid  = tape_valid;
        result.tape_out_sample = tape_val;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_a_reg    <= 8'h00;
            port_c_reg    <= 8'h00;
            c_mask_reg    <= 8'h00;
            bus_mode_reg  <= BUS_INACTIVE;
            psg_index_reg <= 4'h0;
            tape_in_reg   <= 1'b0;
        end else if (item_fire) begin
            port_a_reg    <= port_a_next;
            port_c_reg    <= port_c_next;
            c_mask_reg    <= c_mask_next;
            bus_mode_reg  <= bus_mode_next;
            psg_index_reg <= psg_index_next;
            tape_in_reg   <= tape_in_next;
        end
    end

endmodule

// ----- dv/ppi_port_checker.sv -----
// checker for the parallel port: predicts every port access and compares the result channel
module ppi_port_checker
    import ppipsg_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [MachineIdWidth-1:0] cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [1:0]                s_opcode,
    input  logic [1:0]                s_port_select,
    input  logic [7:0]                s_write_data,
    input  logic [7:0]                s_psg_read_data,
    input  logic                      s_vsync,
    input  logic [7:0]                s_tape_sample,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [7:0]                m_read_data,
    input  logic                      m_psg_write_valid,
    input  logic [7:0]                m_psg_write_data,
    input  logic [3:0]                m_psg_reg_index,
    input  logic [3:0]                m_keyboard_row,
    input  logic                      m_motor_on,
    input  logic                      m_tape_out_valid,
    input  logic [7:0]                m_tape_out_sample,
    output int unsigned               mismatch_count,
    output int unsigned               results_due
);

    // shadow copy of the port state
    logic [MachineIdWidth-1:0] brand_id;
    logic [7:0]                port_a;
    logic [7:0]                port_c;
    logic [7:0]                c_read_mask;
    logic [1:0]                bus_mode;
    logic [3:0]                reg_index;
    logic                      tape_in;

    // results still owed by the block, oldest first
    res_item_t port_results_owed[$];

    // sound-chip bus cycle after a port A or port C write
    function automatic logic sound_bus_cycle();
        if (bus_mode == BUS_LATCH) begin
            reg_index = port_a[3:0];
        end
        return bus_mode == BUS_WRITE;
    endfunction

    // effect of one access on the port state, and the result it returns
    function automatic res_item_t port_access_effect(in_item_t it);
        res_item_t r;
        logic      psg_wr;
        r           = '0;
        r.read_data = ByteAllOnes;
        psg_wr      = 1'b0;
        case (it.opcode)
            OP_REG_WRITE: begin
                case (it.port_select)
                    PORT_A: begin
                        port_a = it.write_data;
                        psg_wr = sound_bus_cycle();
                    end
                    PORT_C: begin
                        port_c   = it.write_data;
                        bus_mode = it.write_data[7:6];
                        psg_wr   = sound_bus_cycle();
                    end
                    PORT_CONTROL: begin
                        if (it.write_data[7]) begin
                            // mode set: port A cleared, read mask from bits 3 and 0
                            port_a = 8'h00;
                            case ({it.write_data[3], it.write_data[0]})
                                2'b11:   c_read_mask = 8'h00;
                                2'b10:   c_read_mask = MaskLowNibble;
                                2'b01:   c_read_mask = MaskHighNibble;
                                default: c_read_mask = ByteAllOnes;
                            endcase
                        end else begin
                            // single port C bit set or clear
                            port_c[it.write_data[3:1]] = it.write_data[0];
                        end
                    end
                    default: ;  // port B write has no effect
                endcase
            end
            OP_REG_READ: begin
                case (it.port_select)
                    PORT_A: begin
                        if (bus_mode == BUS_READ) begin
                            r.read_data = it.psg_read_data;
                        end
                    end
                    PORT_B: r.read_data = {tape_in, 3'b000, brand_id, it.vsync} | RefreshBit;
                    PORT_C: r.read_data = port_c & c_read_mask;
                    default: ;
                endcase
            end
            OP_TAPE_READ: begin
                tape_in = port_c[MotorBitPos] && (it.tape_sample > TapeThreshold);
            end
            default: begin
                if (port_c[MotorBitPos]) begin
                    r.tape_out_valid  = 1'b1;
                    r.tape_out_sample = port_c[TapeOutBitPos] ? TapeHigh : TapeLow;
                end
            end
        endcase
        r.psg_write_valid = psg_wr;
        r.psg_write_data  = psg_wr ? port_a : 8'h00;
        r.psg_reg_index   = reg_index;
        r.keyboard_row    = port_c[3:0];
        r.motor_on        = port_c[MotorBitPos];
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            if (mismatch_count < 10) begin
                $display("mismatch in %s: expected %h, got %h", name, want, got);
            end
            mismatch_count++;
        end
    endtask

    // watch config, result and input channels at each rising edge
    always @(posedge aclk) begin : watch
        res_item_t got;
        res_item_t want;
        if (!aresetn) begin
            brand_id       = MachineIdReset;
            port_a         = '0;
            port_c         = '0;
            c_read_mask    = '0;
            bus_mode       = BUS_INACTIVE;
            reg_index      = '0;
            tape_in        = 1'b0;
            mismatch_count = 0;
            port_results_owed.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                brand_id = cfg_data;
            end
            // result item: compare with the oldest prediction
            if (m_valid && m_ready) begin
                got = {m_read_data, m_psg_write_valid, m_psg_write_data, m_psg_reg_index,
                       m_keyboard_row, m_motor_on, m_tape_out_valid, m_tape_out_sample};
                if (port_results_owed.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("result item with no access pending: %h", got);
                    end
                    mismatch_count++;
                end else begin
                    want = port_results_owed.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("psg_write_valid", 8'(want.psg_write_valid),
                                8'(got.psg_write_valid));
                    check_field("psg_write_data", want.psg_write_data, got.psg_write_data);
                    check_field("psg_reg_index", 8'(want.psg_reg_index),
                                8'(got.psg_reg_index));
                    check_field("keyboard_row", 8'(want.keyboard_row), 8'(got.keyboard_row));
                    check_field("motor_on", 8'(want.motor_on), 8'(got.motor_on));
                    check_field("tape_out_valid", 8'(want.tape_out_valid),
                                8'(got.tape_out_valid));
                    check_field("tape_out_sample", want.tape_out_sample, got.tape_out_sample);
                end
            end
            // input item: predict its result
            if (s_valid && s_ready) begin
                port_results_owed.push_back(port_access_effect({s_opcode, s_port_select,
                    s_write_data, s_psg_read_data, s_vsync, s_tape_sample}));
            end
        end
        results_due = port_results_owed.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// testbench top: clock, reset, port access stimulus and verdict
module tb_top;
    import ppipsg_pkg::*;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [MachineIdWidth-1:0] cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [1:0]                s_opcode;
    logic [1:0]                s_port_select;
    logic [7:0]                s_write_data;
    logic [7:0]                s_psg_read_data;
    logic                      s_vsync;
    logic [7:0]                s_tape_sample;
    logic                      m_valid;
    logic                      m_ready;
    logic [7:0]                m_read_data;
    logic                      m_psg_write_valid;
    logic [7:0]                m_psg_write_data;
    logic [3:0]                m_psg_reg_index;
    logic [3:0]                m_keyboard_row;
    logic                      m_motor_on;
    logic                      m_tape_out_valid;
    logic [7:0]                m_tape_out_sample;
    int unsigned               mismatch_count;
    int unsigned               results_due;

    // idle and stall chances in percent, set per phase
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;

    localparam int unsigned NumPhases = 5;

    ppi_parallel_port_with_psg_control_top DUT (.*);

    ppi_port_checker u_checker (.*);

    always #4 aclk = ~aclk;

    // run limit
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stall bursts
    initial begin
        int unsigned burst;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                burst   = $urandom_range(1, 6);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // access with random side fields
    function automatic in_item_t make_item(logic [1:0] op, logic [1:0] port, logic [7:0] wd);
        in_item_t it;
        it.opcode        = op;
        it.port_select   = port;
        it.write_data    = wd;
        it.psg_read_data = 8'($urandom);
        it.vsync         = 1'($urandom);
        it.tape_sample   = 8'($urandom);
        return it;
    endfunction

    // drive one item, maybe after an idle burst, and wait for its acceptance
    task automatic push_item(in_item_t it);
        int unsigned gap;
        gap = 0;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 6);
        end
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= it.opcode;
        s_port_select   <= it.port_select;
        s_write_data    <= it.write_data;
        s_psg_read_data <= it.psg_read_data;
        s_vsync         <= it.vsync;
        s_tape_sample   <= it.tape_sample;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and let every owed result come back
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (results_due == 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_machine_id(logic [MachineIdWidth-1:0] id);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed sound-chip and tape sequences, some noise
    task automatic run_random_phase(int unsigned n);
        int unsigned sent;
        int unsigned ticks;
        logic [3:0]  idx;
        logic [3:0]  row;
        logic [1:0]  cbits;
        sent = 0;
        while (sent < n) begin
            idx   = 4'($urandom);
            row   = 4'($urandom);
            cbits = 2'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // sound-chip register write
                    push_item(make_item(OP_REG_WRITE, PORT_A, {4'($urandom), idx}));
                    push_item(make_item(OP_REG_WRITE, PORT_C, {BUS_LATCH, cbits, row}));
                    push_item(make_item(OP_REG_WRITE, PORT_A, 8'($urandom)));
                    push_item(make_item(OP_REG_WRITE, PORT_C, {BUS_WRITE, cbits, row}));
                    push_item(make_item(OP_REG_WRITE, PORT_C, {BUS_INACTIVE, cbits, row}));
                    sent += 5;
                end
                3, 4: begin
                    // sound-chip register read
                    push_item(make_item(OP_REG_WRITE, PORT_A, {4'($urandom), idx}));
                    push_item(make_item(OP_REG_WRITE, PORT_C, {BUS_LATCH, cbits, row}));
                    push_item(make_item(OP_REG_WRITE, PORT_C, {BUS_READ, cbits, row}));
                    push_item(make_item(OP_REG_READ, PORT_A, 8'($urandom)));
                    push_item(make_item(OP_REG_READ, 2'($urandom), 8'($urandom)));
                    push_item(make_item(OP_REG_WRITE, PORT_C, {BUS_INACTIVE, cbits, row}));
                    sent += 6;
                end
                5, 6: begin
                    // motor mostly on, tape out bit random, then ticks
                    push_item(make_item(OP_REG_WRITE, PORT_CONTROL, {1'b0, 3'($urandom),
                        3'(MotorBitPos), 1'($urandom_range(0, 3) != 0)}));
                    push_item(make_item(OP_REG_WRITE, PORT_CONTROL, {1'b0, 3'($urandom),
                        3'(TapeOutBitPos), 1'($urandom)}));
                    ticks = $urandom_range(2, 6);
                    repeat (ticks) begin
                        push_item(make_item($urandom_range(0, 1) ? OP_TAPE_READ : OP_TAPE_WRITE,
                                            2'($urandom), 8'($urandom)));
                    end
                    push_item(make_item(OP_REG_READ, PORT_B, 8'($urandom)));
                    sent += ticks + 3;
                end
                7: begin
                    // mode set or bit operation, then port C read
                    push_item(make_item(OP_REG_WRITE, PORT_CONTROL, 8'($urandom)));
                    push_item(make_item(OP_REG_READ, PORT_C, 8'($urandom)));
                    sent += 2;
                end
                default: begin
                    push_item(make_item(2'($urandom), 2'($urandom), 8'($urandom)));
                    sent += 1;
                end
            endcase
        end
    endtask

    // main sequence
    initial begin
        in_item_t    it;
        int unsigned ph;
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_opcode        = OP_REG_WRITE;
        s_port_select   = PORT_A;
        s_write_data    = '0;
        s_psg_read_data = '0;
        s_vsync         = 1'b0;
        s_tape_sample   = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset machine id, reads of every port
        push_item(make_item(OP_REG_READ, PORT_B, 8'h00));
        push_item(make_item(OP_REG_READ, PORT_C, 8'h00));
        push_item(make_item(OP_REG_READ, PORT_A, 8'h00));
        push_item(make_item(OP_REG_READ, PORT_CONTROL, 8'h00));
        // index latch, then register writes
        push_item(make_item(OP_REG_WRITE, PORT_A, 8'h3C));
        push_item(make_item(OP_REG_WRITE, PORT_C, 8'hC0));
        push_item(make_item(OP_REG_WRITE, PORT_C, 8'h80));
        push_item(make_item(OP_REG_WRITE, PORT_A, 8'hA5));
        // read mode, sound-chip data returned on port A
        push_item(make_item(OP_REG_WRITE, PORT_C, 8'h4F));
        it = make_item(OP_REG_READ, PORT_A, 8'h00);
        it.psg_read_data = 8'h5A;
        push_item(it);
        // port B write ignored
        push_item(make_item(OP_REG_WRITE, PORT_B, 8'hFF));
        // the four read masks on mode set
        push_item(make_item(OP_REG_WRITE, PORT_CONTROL, 8'h89));
        push_item(make_item(OP_REG_READ, PORT_C, 8'h00));
        push_item(make_item(OP_REG_WRITE, PORT_CONTROL, 8'h88));
        push_item(make_item(OP_REG_READ, PORT_C, 8'h00));
        push_item(make_item(OP_REG_WRITE, PORT_CONTROL, 8'h81));
        push_item(make_item(OP_REG_READ, PORT_C, 8'h00));
        push_item(make_item(OP_REG_WRITE, PORT_CONTROL, 8'h80));
        push_item(make_item(OP_REG_READ, PORT_C, 8'h00));
        // motor on: tape out low then high
        push_item(make_item(OP_REG_WRITE, PORT_CONTROL, 8'h09));
        push_item(make_item(OP_TAPE_WRITE, PORT_A, 8'h00));
        push_item(make_item(OP_REG_WRITE, PORT_CONTROL, 8'h0B));
        push_item(make_item(OP_TAPE_WRITE, PORT_A, 8'h00));
        // tape input just above and at the threshold
        it = make_item(OP_TAPE_READ, PORT_A, 8'h00);
        it.tape_sample = 8'h86;
        push_item(it);
        push_item(make_item(OP_REG_READ, PORT_B, 8'h00));
        it.tape_sample = 8'h85;
        push_item(it);
        // motor off: tape input forced low, no tape output
        push_item(make_item(OP_REG_WRITE, PORT_CONTROL, 8'h08));
        it.tape_sample = 8'hFF;
        push_item(it);
        push_item(make_item(OP_TAPE_WRITE, PORT_A, 8'h00));
        settle();

        // random phases, each under a new machine id and idle pattern
        for (ph = 0; ph < NumPhases; ph++) begin
            write_machine_id(ph == 0 ? 3'd0 : ph == 1 ? 3'd7 : 3'($urandom));
            if (ph == 1 || ph == NumPhases - 1) begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end else begin
                src_idle_pct   = $urandom_range(10, 60);
                sink_stall_pct = $urandom_range(10, 60);
            end
            run_random_phase(100);
            settle();
        end

        if (mismatch_count == 0 && results_due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ppipsg_pkg.sv
rtl/ppipsg_exec.sv
rtl/ppi_parallel_port_with_psg_control_top.sv
dv/ppi_port_checker.sv
dv/tb_top.sv
